[rtl/core/assert_macros.svh]
// Assertion helpers used by the RTL of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge while reset is released.
`define OADC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising clock edge, including during reset.
`define OADC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/core/oadc_pkg.sv]
package oadc_pkg;

  localparam int unsigned DistW   = 11;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgDataW = 11;

  // Division by 56 is a shift by 3 followed by a multiply with the
  // reciprocal of 7, exact for all 13-bit values.
  localparam int unsigned RecipShift = 16;
  localparam logic [13:0] Recip7 = 14'd9363;

  localparam logic [3:0] PatStraight = 4'b1001;
  localparam logic [3:0] PatLeft     = 4'b0101;
  localparam logic [3:0] PatRight    = 4'b1010;
  localparam logic [3:0] PatBack     = 4'b0110;
  localparam logic [3:0] PatStop     = 4'b0000;

  localparam logic [1:0] SensLeft  = 2'd1;
  localparam logic [1:0] SensRight = 2'd2;
  localparam logic [1:0] SensBoth  = 2'd3;

  localparam logic [7:0] CmdA    = 8'h41;
  localparam logic [7:0] CmdB    = 8'h42;
  localparam logic [7:0] CmdC    = 8'h43;
  localparam logic [7:0] CmdD    = 8'h44;
  localparam logic [7:0] CmdE    = 8'h45;
  localparam logic [7:0] CmdF    = 8'h46;
  localparam logic [7:0] CmdHalt = 8'h30;

  typedef enum logic [1:0] {
    RegNear   = 2'd0,
    RegClear  = 2'd1,
    RegHalt   = 2'd2,
    RegPeriod = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PhChkL   = 4'd0,
    PhLoopL  = 4'd1,
    PhChkR   = 4'd2,
    PhLoopR  = 4'd3,
    PhChkB   = 4'd4,
    PhSmpL   = 4'd5,
    PhSmpR   = 4'd6,
    PhLoopB  = 4'd7,
    PhManual = 4'd8
  } phase_e;

  typedef struct packed {
    logic             manual_active;
    logic [ByteW-1:0] report_byte;
    logic             report_valid;
    logic [1:0]       next_sensor;
    logic [3:0]       motor_pins;
  } result_t;

endpackage

[rtl/core/obstacle_avoidance_drive_controller.sv]
// Path: an accepted item is held in the input register, and its result in the
// result register, from which it can be taken.
// Throughput: one item per cycle while the output is not stalled; the state update
// and the divide by 56 sit in the single logic stage between the two registers.
// Reset: asynchronous, active low; limits return to 20/30/10/20, the pass
// restarts at the left check in automatic mode driving straight.
`include "assert_macros.svh"

module obstacle_avoidance_drive_controller
  import oadc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [InDataW-1:0]  s_tdata_i,   // echo_ticks[15:0], rx_byte[23:16]
  input  logic                s_tuser_i,   // kind
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [OutDataW-1:0] m_tdata_o,   // motor_pins[3:0], next_sensor[5:4],
                                           // report_valid[6], report_byte[14:7],
                                           // manual_active[15]
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [DistW-1:0] near_q, clear_q;
  logic [ByteW-1:0] halt_q, period_q;

  logic               in_vld_q;
  logic               in_kind_q;
  logic [TicksW-1:0]  in_ticks_q;
  logic [ByteW-1:0]   in_rx_q;

  logic               out_vld_q;
  result_t            out_q, res_d;

  phase_e             phase_q, phase_d;
  logic               manual_q, manual_d;
  logic [ByteW-1:0]   cmd_q, cmd_d;
  logic [DistW-1:0]   left_q, left_d;
  logic [ByteW-1:0]   count_q, count_d;
  logic [3:0]         pat_q, pat_d;

  logic               advance;
  logic [26:0]        prod;
  logic [DistW-1:0]   distance;
  logic [ByteW-1:0]   front, count_inc, cmd_eff;
  logic               rep_valid;

  assign cfg_ready_o = 1'b1;
  assign advance     = !out_vld_q || m_tready_i;
  assign s_tready_o  = !in_vld_q || advance;
  assign m_tvalid_o  = out_vld_q;
  assign m_tdata_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q   <= DistW'(20);
      clear_q  <= DistW'(30);
      halt_q   <= ByteW'(10);
      period_q <= ByteW'(20);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegNear:   near_q   <= cfg_data_i;
        RegClear:  clear_q  <= cfg_data_i;
        RegHalt:   halt_q   <= cfg_data_i[ByteW-1:0];
        RegPeriod: period_q <= cfg_data_i[ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_tready_o) begin
      in_vld_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      in_kind_q  <= s_tuser_i;
      in_ticks_q <= s_tdata_i[15:0];
      in_rx_q    <= s_tdata_i[23:16];
    end
  end

  assign prod      = 27'(in_ticks_q[15:3]) * 27'(Recip7);
  assign distance  = prod[26:16];
  assign front     = distance[ByteW-1:0];
  assign count_inc = count_q + 8'd1;

  always_comb begin
    phase_d   = phase_q;
    manual_d  = manual_q;
    cmd_d     = cmd_q;
    left_d    = left_q;
    count_d   = count_q;
    pat_d     = pat_q;
    rep_valid = 1'b0;
    cmd_eff   = cmd_q;
    if (in_kind_q) begin
      manual_d = 1'b1;
      cmd_d    = in_rx_q;
    end else begin
      unique case (phase_q)
        PhLoopL: begin
          if (distance >= clear_q) begin
            pat_d   = PatStraight;
            phase_d = PhChkR;
          end
        end
        PhChkR: begin
          if (distance < near_q) begin
            pat_d   = PatRight;
            phase_d = PhLoopR;
          end else begin
            pat_d   = PatStraight;
            phase_d = PhChkB;
          end
        end
        PhLoopR: begin
          if (distance >= clear_q) begin
            pat_d   = PatStraight;
            phase_d = PhChkB;
          end
        end
        PhChkB: begin
          if (distance < near_q) begin
            phase_d = PhSmpL;
          end else begin
            pat_d   = PatStraight;
            phase_d = manual_q ? PhManual : PhChkL;
          end
        end
        PhSmpL: begin
          left_d  = distance;
          phase_d = PhSmpR;
        end
        PhSmpR: begin
          pat_d   = (left_q > distance) ? PatRight : PatLeft;
          phase_d = PhLoopB;
        end
        PhLoopB: begin
          if (distance >= clear_q) begin
            pat_d   = PatStraight;
            phase_d = manual_q ? PhManual : PhChkL;
          end
        end
        PhManual: begin
          if (count_inc == period_q) begin
            rep_valid = 1'b1;
            count_d   = '0;
          end else begin
            count_d = count_inc;
          end
          if (front < halt_q) begin
            pat_d   = PatStop;
            cmd_eff = CmdHalt;
          end
          cmd_d = cmd_eff;
          unique case (cmd_eff)
            CmdA:    pat_d    = PatStraight;
            CmdB:    pat_d    = PatLeft;
            CmdC:    pat_d    = PatRight;
            CmdD:    pat_d    = PatBack;
            CmdE:    pat_d    = PatStop;
            CmdF:    manual_d = 1'b0;
            default: ;
          endcase
          if (cmd_eff == CmdF) begin
            phase_d = PhChkL;
          end
        end
        default: begin
          if (distance < near_q) begin
            pat_d   = PatLeft;
            phase_d = PhLoopL;
          end else begin
            pat_d   = PatStraight;
            phase_d = PhChkR;
          end
        end
      endcase
    end

    res_d.motor_pins    = pat_d;
    res_d.report_valid  = rep_valid;
    res_d.report_byte   = rep_valid ? front : '0;
    res_d.manual_active = (phase_d == PhManual);
    unique case (phase_d)
      PhChkR, PhLoopR, PhSmpR:   res_d.next_sensor = SensRight;
      PhChkB, PhLoopB, PhManual: res_d.next_sensor = SensBoth;
      default:                   res_d.next_sensor = SensLeft;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhChkL;
      manual_q <= 1'b0;
      cmd_q    <= '0;
      left_q   <= '0;
      count_q  <= '0;
      pat_q    <= PatStraight;
    end else if (in_vld_q && advance) begin
      phase_q  <= phase_d;
      manual_q <= manual_d;
      cmd_q    <= cmd_d;
      left_q   <= left_d;
      count_q  <= count_d;
      pat_q    <= pat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      out_q <= res_d;
    end
  end

  `OADC_ASSERT(a_manual_phase_flag, (phase_q == PhManual) |-> manual_q,
               "manual phase without manual flag")
  `OADC_ASSERT(a_manual_both,
               (out_vld_q && out_q.manual_active) |-> (out_q.next_sensor == SensBoth),
               "manual result must request both sensors")
  `OADC_ASSERT(a_report_zero, (out_vld_q && !out_q.report_valid) |-> (out_q.report_byte == '0),
               "report byte set without report")
  `OADC_ASSERT(a_stage_hold, (in_vld_q && !advance) |=> (in_vld_q && $stable(in_ticks_q)),
               "input stage lost a stalled item")

endmodule

[bench/oadc_drive_checker.sv]
`timescale 1ns / 1ps

module oadc_drive_checker
  import oadc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,   // echo_ticks[15:0], rx_byte[23:16]
  input  logic                s_tuser_i,   // kind
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,   // motor_pins[3:0], next_sensor[5:4],
                                           // report_valid[6], report_byte[14:7],
                                           // manual_active[15]
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  localparam int unsigned TicksPerUnit = 56;

  logic [DistW-1:0] near_lim;
  logic [DistW-1:0] clear_lim;
  logic [7:0]       halt_lim;
  logic [7:0]       period_lim;

  logic             manual_req;
  logic [ByteW-1:0] cmd_char;
  phase_e           phase;
  logic [DistW-1:0] left_dist;
  logic             steer_right;
  logic [7:0]       report_cnt;
  logic [3:0]       motors;

  result_t          drive_q[$];
  result_t          want_r;
  result_t          got_r;
  int unsigned      fails;
  int unsigned      pending;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic phase_e finish_pass();
    motors = PatStraight;
    if (manual_req) begin
      return PhManual;
    end
    return PhChkL;
  endfunction

  function automatic result_t predict_drive(input logic kind, input logic [TicksW-1:0] ticks,
                                            input logic [ByteW-1:0] rx);
    logic [DistW-1:0] distance;
    logic [7:0]       front;
    phase_e           ph;
    result_t          res;
    distance = DistW'(ticks / TicksPerUnit);
    front    = distance[7:0];
    res      = '0;
    ph       = phase;
    if (ph > PhManual) begin
      ph = PhChkL;
    end
    if (kind) begin
      manual_req = 1'b1;
      cmd_char   = rx;
    end else begin
      case (ph)
        PhLoopL: begin
          if (distance >= clear_lim) begin
            motors = PatStraight;
            ph     = PhChkR;
          end
        end
        PhChkR: begin
          if (distance < near_lim) begin
            motors = PatRight;
            ph     = PhLoopR;
          end else begin
            motors = PatStraight;
            ph     = PhChkB;
          end
        end
        PhLoopR: begin
          if (distance >= clear_lim) begin
            motors = PatStraight;
            ph     = PhChkB;
          end
        end
        PhChkB: begin
          if (distance < near_lim) begin
            ph = PhSmpL;
          end else begin
            ph = finish_pass();
          end
        end
        PhSmpL: begin
          left_dist = distance;
          ph        = PhSmpR;
        end
        PhSmpR: begin
          steer_right = (left_dist > distance);
          motors      = steer_right ? PatRight : PatLeft;
          ph          = PhLoopB;
        end
        PhLoopB: begin
          if (distance >= clear_lim) begin
            ph = finish_pass();
          end
        end
        PhManual: begin
          report_cnt = report_cnt + 8'd1;
          if (report_cnt == period_lim) begin
            res.report_valid = 1'b1;
            res.report_byte  = front;
            report_cnt       = '0;
          end
          if (front < halt_lim) begin
            motors   = PatStop;
            cmd_char = CmdHalt;
          end
          case (cmd_char)
            CmdA: motors = PatStraight;
            CmdB: motors = PatLeft;
            CmdC: motors = PatRight;
            CmdD: motors = PatBack;
            CmdE: motors = PatStop;
            CmdF: manual_req = 1'b0;
            default: ;
          endcase
          if (!manual_req) begin
            ph = PhChkL;
          end
        end
        default: begin
          if (distance < near_lim) begin
            motors = PatLeft;
            ph     = PhLoopL;
          end else begin
            motors = PatStraight;
            ph     = PhChkR;
          end
        end
      endcase
    end
    phase = ph;
    res.motor_pins = motors;
    case (ph)
      PhChkR, PhLoopR, PhSmpR:   res.next_sensor = SensRight;
      PhChkB, PhLoopB, PhManual: res.next_sensor = SensBoth;
      default:                   res.next_sensor = SensLeft;
    endcase
    res.manual_active = (ph == PhManual);
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_lim    = 11'd20;
      clear_lim   = 11'd30;
      halt_lim    = 8'd10;
      period_lim  = 8'd20;
      manual_req  = 1'b0;
      cmd_char    = '0;
      phase       = PhChkL;
      left_dist   = '0;
      steer_right = 1'b0;
      report_cnt  = '0;
      motors      = PatStraight;
      drive_q.delete();
      fails       = 0;
      pending     = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got_r = result_t'(m_tdata_i);
        if (drive_q.size() == 0) begin
          $error("result 0x%0h arrived with no item outstanding", m_tdata_i);
          fails++;
        end else begin
          want_r = drive_q.pop_front();
          check_field("motor_pins", want_r.motor_pins, got_r.motor_pins);
          check_field("next_sensor", want_r.next_sensor, got_r.next_sensor);
          check_field("report_valid", want_r.report_valid, got_r.report_valid);
          check_field("report_byte", want_r.report_byte, got_r.report_byte);
          check_field("manual_active", want_r.manual_active, got_r.manual_active);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegNear:   near_lim   = cfg_data_i;
          RegClear:  clear_lim  = cfg_data_i;
          RegHalt:   halt_lim   = cfg_data_i[7:0];
          RegPeriod: period_lim = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        drive_q.push_back(predict_drive(s_tuser_i, s_tdata_i[TicksW-1:0],
                                        s_tdata_i[InDataW-1:TicksW]));
      end
      pending = drive_q.size();
    end
  end

endmodule

[bench/tb_obstacle_avoidance_drive_controller.sv]
`timescale 1ns / 1ps

module tb_obstacle_avoidance_drive_controller;
  import oadc_pkg::*;

  localparam int unsigned TicksPerUnit = 56;
  localparam int unsigned MaxDist      = 1170;
  localparam logic        KindEcho     = 1'b0;
  localparam logic        KindCmd      = 1'b1;

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                s_tvalid = 1'b0;
  logic [InDataW-1:0]  s_tdata  = '0;
  logic                s_tuser  = 1'b0;
  logic                m_tready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [1:0]          cfg_index = RegNear;
  logic [CfgDataW-1:0] cfg_data  = '0;

  logic                s_tready;
  logic                m_tvalid;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_ready;
  int unsigned         fail_count;
  int unsigned         pending;

  bit                  no_idle = 1'b0;
  int unsigned         cur_near  = 20;
  int unsigned         cur_clear = 30;

  obstacle_avoidance_drive_controller dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_o  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  oadc_drive_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic send_item(input logic kind, input logic [TicksW-1:0] ticks,
                           input logic [ByteW-1:0] rx);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rx, ticks};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_echo(input int unsigned distance);
    int unsigned ticks;
    ticks = distance * TicksPerUnit + $urandom_range(0, (distance == MaxDist) ? 15 : 55);
    send_item(KindEcho, TicksW'(ticks), ByteW'($urandom));
  endtask

  task automatic send_cmd(input logic [ByteW-1:0] ch);
    send_item(KindCmd, TicksW'($urandom), ch);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgDataW'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_limits(input int unsigned near, input int unsigned clear,
                                input int unsigned halt, input int unsigned period);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    write_reg(RegNear, near);
    write_reg(RegClear, clear);
    write_reg(RegHalt, halt);
    write_reg(RegPeriod, period);
    cfg_valid <= 1'b0;
    cur_near  = near;
    cur_clear = clear;
  endtask

  function automatic int unsigned pick_dist();
    int unsigned d;
    case ($urandom_range(0, 6))
      0, 1, 2: d = (cur_near > 0) ? $urandom_range(0, cur_near - 1) : 0;
      3: begin
        case ($urandom_range(0, 3))
          0:       d = (cur_near > 0) ? cur_near - 1 : 0;
          1:       d = cur_near;
          2:       d = (cur_clear > 0) ? cur_clear - 1 : 0;
          default: d = cur_clear;
        endcase
      end
      4, 5: d = $urandom_range(cur_clear, MaxDist);
      default: d = $urandom_range(0, 300);
    endcase
    return d;
  endfunction

  function automatic logic [ByteW-1:0] pick_cmd();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 8) begin
      return CmdF;
    end else if (sel < 16) begin
      return CmdA + ByteW'($urandom_range(0, 4));
    end else if (sel == 16) begin
      return CmdHalt;
    end
    return ByteW'($urandom);
  endfunction

  task automatic run_random(input int unsigned count);
    int unsigned sel;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        no_idle = !no_idle;
      end
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        send_cmd(pick_cmd());
      end else if (sel < 10) begin
        send_item(KindEcho, TicksW'($urandom), ByteW'($urandom));
      end else if (sel < 12) begin
        send_item(KindEcho, ($urandom_range(0, 1) != 0) ? '1 : '0, ByteW'($urandom));
      end else begin
        send_echo(pick_dist());
      end
    end
  endtask

  initial begin
    @(posedge rst_n);
    forever begin
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Full automatic pass with every turn, then the pass that hands over to manual mode.
    send_item(KindEcho, '0, '1);
    send_echo(29);
    send_echo(30);
    send_echo(19);
    send_item(KindEcho, '1, '0);
    send_echo(0);
    send_echo(12);
    send_echo(5);
    send_echo(30);
    send_echo(MaxDist);
    send_echo(MaxDist);
    send_echo(0);
    send_echo(7);
    send_cmd(CmdA);
    send_echo(7);
    send_echo(MaxDist);
    send_echo(100);
    send_cmd(CmdB);
    send_echo(200);
    send_cmd(CmdD);
    send_echo(MaxDist);
    send_cmd(8'h7A);
    send_echo(265);
    send_cmd(CmdF);
    send_echo(50);

    run_random(120);
    for (int unsigned p = 1; p < 6; p++) begin
      case (p)
        1:       program_limits(0, 0, 0, 1);
        2:       program_limits(MaxDist, MaxDist, 255, 255);
        3:       program_limits(20, 30, 10, 20);
        default: program_limits($urandom_range(0, 200), $urandom_range(0, 250),
                                $urandom_range(0, 255), $urandom_range(1, 40));
      endcase
      run_random(115);
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_obstacle_avoidance_drive_controller: done, clean");
    end else begin
      $display("tb_obstacle_avoidance_drive_controller: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_obstacle_avoidance_drive_controller: done, errors");
    $finish;
  end

endmodule

[obstacle_avoidance_drive_controller.f]
+incdir+rtl/core
rtl/core/oadc_pkg.sv
rtl/core/obstacle_avoidance_drive_controller.sv
bench/oadc_drive_checker.sv
bench/tb_obstacle_avoidance_drive_controller.sv
